// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== rtl/core/igdr_pkg.sv =====
// Shared types, constants and helpers for the gated dead-reckoning block.
// No dependencies.
package igdr_pkg;

    localparam int WIN_DEPTH  = 16;
    localparam int IDX_W      = $clog2(WIN_DEPTH);
    localparam int LEN_W      = IDX_W + 1;
    localparam int CFG_DATA_W = 47;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 8;
    localparam int DIV_CNT_W  = 5;
    localparam int DIV_FULL_STEPS  = DIV_NUM_W / 2;
    localparam int DIV_SHORT_STEPS = 10;
    localparam int PROD_W     = 50;
    localparam int SUM1_W     = 20;
    localparam int SUM2_W     = 36;

    localparam logic [4:0]  RST_SMOOTH_LEN    = 5'd13;
    localparam logic [4:0]  RST_VAR_LEN       = 5'd13;
    localparam logic [46:0] RST_VAR_LOW       = 47'd42950;
    localparam logic [46:0] RST_VAR_HIGH      = 47'd21474836;
    localparam logic [46:0] RST_ROT_THRESHOLD = 47'd42949673;
    localparam logic [15:0] RST_TIME_STEP     = 16'd3277;
    localparam logic [23:0] RST_ROT_GAIN      = 24'd187749;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTH_LEN,
        REG_VAR_LEN,
        REG_VAR_LOW,
        REG_VAR_HIGH,
        REG_ROT_THRESHOLD,
        REG_TIME_STEP,
        REG_ROT_GAIN
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] acc_sample;
        logic signed [15:0] gyro_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] acc_smoothed;
        logic signed [15:0] gyro_smoothed;
        logic signed [47:0] acc_variance;
        logic signed [47:0] gyro_variance;
        logic               rotating;
        logic               moving;
        logic signed [31:0] velocity;
        logic signed [39:0] angle;
        logic signed [47:0] displacement;
    } out_word_t;

    typedef struct packed {
        logic push_raw;
        logic clr;
        logic acc_avg;
        logic acc_var;
        logic ch;
        logic avg_div_start;
        logic avg_store;
        logic push_sm;
        logic sq_mul;
        logic var_div_start;
        logic var_store;
        logic rot_mul;
        logic angle_upd;
        logic vel_mul;
        logic vel_upd;
        logic disp_mul;
        logic disp_upd;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic avg_last;
        logic var_last;
        logic div_busy;
        logic div_done;
    } dp_stat_t;

    function automatic logic signed [63:0] sat_bits(input logic signed [63:0] v,
                                                    input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

// ===== rtl/core/igdr_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on igdr_pkg.
interface igdr_in_if;
    logic               valid;
    logic               ready;
    igdr_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface igdr_out_if;
    logic                valid;
    logic                ready;
    igdr_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/igdr_div.sv =====
// Unsigned iterative divider, two quotient bits per cycle.
// Depends on igdr_pkg.
module igdr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               short_mode,
    input  logic [igdr_pkg::DIV_NUM_W-1:0]     num,
    input  logic [igdr_pkg::DIV_DEN_W-1:0]     den,
    output logic                               busy,
    output logic                               done,
    output logic [igdr_pkg::DIV_NUM_W-1:0]     quo
);
    import igdr_pkg::*;

    localparam int SHORT_SHIFT = DIV_NUM_W - 2 * DIV_SHORT_STEPS;

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DEN_W:0]   trial;

    // two restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_next, num_next[DIV_NUM_W-1]};
            num_next = {num_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_mode ? DIV_CNT_W'(DIV_SHORT_STEPS)
                                       : DIV_CNT_W'(DIV_FULL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= short_mode ? (num << SHORT_SHIFT) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;
endmodule

// ===== rtl/core/igdr_datapath.sv =====
// Datapath: sample windows, sums, products, divider, gating and integrators.
// Depends on igdr_pkg and igdr_div.
module igdr_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [igdr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [igdr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  igdr_pkg::in_word_t                    in_data,
    input  igdr_pkg::dp_cmd_t                     cmd,
    output igdr_pkg::dp_stat_t                    stat,
    output igdr_pkg::out_word_t                   out_data
);
    import igdr_pkg::*;

    // configuration
    logic [4:0]  smooth_len_reg, var_len_reg;
    logic [46:0] var_low_reg, var_high_reg, rot_threshold_reg;
    logic [15:0] time_step_reg;
    logic [23:0] rot_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_len_reg    <= RST_SMOOTH_LEN;
            var_len_reg       <= RST_VAR_LEN;
            var_low_reg       <= RST_VAR_LOW;
            var_high_reg      <= RST_VAR_HIGH;
            rot_threshold_reg <= RST_ROT_THRESHOLD;
            time_step_reg     <= RST_TIME_STEP;
            rot_gain_reg      <= RST_ROT_GAIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SMOOTH_LEN:    smooth_len_reg    <= cfg_data[4:0];
                REG_VAR_LEN:       var_len_reg       <= cfg_data[4:0];
                REG_VAR_LOW:       var_low_reg       <= cfg_data;
                REG_VAR_HIGH:      var_high_reg      <= cfg_data;
                REG_ROT_THRESHOLD: rot_threshold_reg <= cfg_data;
                REG_TIME_STEP:     time_step_reg     <= cfg_data[15:0];
                REG_ROT_GAIN:      rot_gain_reg      <= cfg_data[23:0];
                default:           ;
            endcase
        end
    end

    logic [LEN_W-1:0] sl, vl;
    assign sl = (smooth_len_reg == '0) ? LEN_W'(1)
              : (smooth_len_reg > 5'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH) : smooth_len_reg[LEN_W-1:0];
    assign vl = (var_len_reg < 5'd2) ? LEN_W'(2)
              : (var_len_reg > 5'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH) : var_len_reg[LEN_W-1:0];

    // windows, index 0 = newest; first index is the channel (0 accel, 1 gyro)
    logic signed [15:0] raw_win[2][WIN_DEPTH];
    logic signed [15:0] sm_win[2][WIN_DEPTH];
    logic signed [15:0] a_sm_reg, g_sm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    raw_win[c][i] <= '0;
                    sm_win[c][i]  <= '0;
                end
        end
        else
        begin
            if (cmd.push_raw)
            begin
                for (int i = WIN_DEPTH - 1; i > 0; i--)
                begin
                    raw_win[0][i] <= raw_win[0][i-1];
                    raw_win[1][i] <= raw_win[1][i-1];
                end
                raw_win[0][0] <= in_data.acc_sample;
                raw_win[1][0] <= in_data.gyro_sample;
            end
            if (cmd.push_sm)
            begin
                for (int i = WIN_DEPTH - 1; i > 0; i--)
                begin
                    sm_win[0][i] <= sm_win[0][i-1];
                    sm_win[1][i] <= sm_win[1][i-1];
                end
                sm_win[0][0] <= a_sm_reg;
                sm_win[1][0] <= g_sm_reg;
            end
        end
    end

    // window walk
    logic [IDX_W-1:0]         idx_reg;
    logic signed [SUM1_W-1:0] sum1_reg;
    logic [SUM2_W-1:0]        sum2_reg;
    logic signed [15:0]       tap;
    logic signed [31:0]       tap_sq;

    assign tap    = cmd.acc_var ? sm_win[cmd.ch][idx_reg] : raw_win[cmd.ch][idx_reg];
    assign tap_sq = tap * tap;

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            idx_reg  <= '0;
            sum1_reg <= '0;
            sum2_reg <= '0;
        end
        else if (cmd.acc_avg || cmd.acc_var)
        begin
            idx_reg  <= idx_reg + 1'b1;
            sum1_reg <= sum1_reg + SUM1_W'(tap);
            sum2_reg <= sum2_reg + {4'b0, tap_sq};
        end
    end

    assign stat.avg_last = (idx_reg == IDX_W'(sl - 1'b1));
    assign stat.var_last = (idx_reg == IDX_W'(vl - 1'b1));

    // divider feed
    logic [SUM1_W-1:0]    sum1_mag;
    logic [40:0]          vl_s2;
    logic [40:0]          var_num;
    logic [9:0]           pairs;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] quo;
    logic signed [PROD_W-1:0] prod_reg;

    assign sum1_mag = sum1_reg[SUM1_W-1] ? SUM1_W'(-sum1_reg) : SUM1_W'(sum1_reg);
    assign vl_s2    = {36'b0, vl} * {5'b0, sum2_reg};
    assign var_num  = (vl_s2 > prod_reg[40:0]) ? vl_s2 - prod_reg[40:0] : '0;
    assign pairs    = {5'b0, vl} * {5'b0, vl - 1'b1};
    assign div_num  = cmd.var_div_start ? {var_num[39:0], 16'b0}
                                        : {{(DIV_NUM_W-SUM1_W){1'b0}}, sum1_mag};
    assign div_den  = cmd.var_div_start ? pairs[DIV_DEN_W-1:0]
                                        : {{(DIV_DEN_W-LEN_W){1'b0}}, sl};

    igdr_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.avg_div_start || cmd.var_div_start),
        .short_mode (cmd.avg_div_start),
        .num        (div_num),
        .den        (div_den),
        .busy       (stat.div_busy),
        .done       (stat.div_done),
        .quo        (quo)
    );

    // averages and variances
    logic [LEN_W-1:0]   seen_reg;
    logic               avg_fill, var_fill;
    logic signed [15:0] avg_val;
    logic signed [47:0] var_val;
    logic signed [47:0] a_var_reg, g_var_reg;
    logic signed [15:0] sm_new;

    assign avg_fill = ({1'b0, seen_reg} + 1'b1) < {1'b0, sl};
    assign var_fill = ({1'b0, seen_reg} + 1'b1) < {1'b0, vl};
    assign avg_val  = avg_fill ? raw_win[cmd.ch][0]
                    : (sum1_reg[SUM1_W-1] ? -$signed(quo[15:0]) : $signed(quo[15:0]));
    assign sm_new   = sm_win[cmd.ch][0];
    assign var_val  = var_fill ? {{8{sm_new[15]}}, sm_new, 24'b0}
                    : ((quo > DIV_NUM_W'({47{1'b1}})) ? {1'b0, {47{1'b1}}}
                                                     : $signed(quo[47:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.avg_store)
        begin
            if (cmd.ch)
                g_sm_reg <= avg_val;
            else
                a_sm_reg <= avg_val;
        end
        if (cmd.var_store)
        begin
            if (cmd.ch)
                g_var_reg <= var_val;
            else
                a_var_reg <= var_val;
        end
    end

    // products, one per cycle
    logic signed [39:0] sq40;
    logic signed [40:0] rot41;
    logic signed [32:0] vel33;
    logic signed [32:0] vsum;
    logic signed [49:0] disp50;
    logic signed [31:0] vel_reg, prev_reg;

    assign sq40   = sum1_reg * sum1_reg;
    assign rot41  = g_sm_reg * $signed({1'b0, rot_gain_reg});
    assign vel33  = a_sm_reg * $signed({1'b0, time_step_reg});
    assign vsum   = vel_reg + prev_reg;
    assign disp50 = vsum * $signed({1'b0, time_step_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
            prod_reg <= PROD_W'(sq40);
        else if (cmd.rot_mul)
            prod_reg <= PROD_W'(rot41);
        else if (cmd.vel_mul)
            prod_reg <= PROD_W'(vel33);
        else if (cmd.disp_mul)
            prod_reg <= disp50;
    end

    // gating
    logic [47:0] a_abs, g_abs;
    logic        rot_now, mov_now;

    assign a_abs   = a_var_reg[47] ? 48'(-a_var_reg) : 48'(a_var_reg);
    assign g_abs   = g_var_reg[47] ? 48'(-g_var_reg) : 48'(g_var_reg);
    assign rot_now = g_abs > {1'b0, rot_threshold_reg};
    assign mov_now = (a_abs > {1'b0, var_low_reg}) && (a_abs < {1'b0, var_high_reg})
                  && (g_var_reg < $signed({1'b0, rot_threshold_reg}));

    // integrators
    logic signed [39:0] angle_reg;
    logic signed [47:0] disp_reg;
    logic               rot_reg, mov_reg;
    logic signed [63:0] angle_sum, vel_sum, disp_sum;

    assign angle_sum = 64'(angle_reg) + 64'(prod_reg >>> 8);
    assign vel_sum   = 64'(prev_reg) + 64'(prod_reg >>> 8);
    assign disp_sum  = 64'(disp_reg) + 64'(prod_reg >>> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            prev_reg  <= '0;
            vel_reg   <= '0;
            angle_reg <= '0;
            disp_reg  <= '0;
            rot_reg   <= 1'b0;
            mov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.angle_upd)
            begin
                rot_reg <= rot_now;
                if (rot_now)
                    angle_reg <= 40'(sat_bits(angle_sum, 40));
            end
            if (cmd.vel_upd)
            begin
                mov_reg <= mov_now;
                vel_reg <= mov_now ? 32'(sat_bits(vel_sum, 32)) : '0;
            end
            if (cmd.disp_upd)
            begin
                if (mov_reg)
                    disp_reg <= 48'(sat_bits(disp_sum, 48));
                prev_reg <= vel_reg;
                if (seen_reg != LEN_W'(WIN_DEPTH))
                    seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data.acc_smoothed  <= a_sm_reg;
            out_data.gyro_smoothed <= g_sm_reg;
            out_data.acc_variance  <= a_var_reg;
            out_data.gyro_variance <= g_var_reg;
            out_data.rotating      <= rot_reg;
            out_data.moving        <= mov_reg;
            out_data.velocity      <= vel_reg;
            out_data.angle         <= angle_reg;
            out_data.displacement  <= disp_reg;
        end
    end
endmodule

// ===== rtl/core/igdr_ctrl.sv =====
// Sequencer for one sample word: window walks, divisions, integration steps.
// Depends on igdr_pkg.
module igdr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  igdr_pkg::dp_stat_t stat,
    output igdr_pkg::dp_cmd_t  cmd
);
    import igdr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_SUM,
        S_AVG_DIV_GO,
        S_AVG_DIV_WAIT,
        S_PUSH_SM,
        S_VAR_SUM,
        S_VAR_SQ,
        S_VAR_DIV_GO,
        S_VAR_DIV_WAIT,
        S_ROT_MUL,
        S_ROT_UPD,
        S_VEL_MUL,
        S_VEL_UPD,
        S_DISP_MUL,
        S_DISP_UPD,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   ch_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   load_now;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign load_now  = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        cmd    = '0;
        cmd.ch = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.push_raw = in_valid;
                cmd.clr      = in_valid;
            end
            S_AVG_SUM:      cmd.acc_avg       = 1'b1;
            S_AVG_DIV_GO:   cmd.avg_div_start = 1'b1;
            S_AVG_DIV_WAIT:
            begin
                cmd.avg_store = stat.div_done;
                cmd.clr       = stat.div_done;
            end
            S_PUSH_SM:
            begin
                cmd.push_sm = 1'b1;
                cmd.clr     = 1'b1;
            end
            S_VAR_SUM:      cmd.acc_var       = 1'b1;
            S_VAR_SQ:       cmd.sq_mul        = 1'b1;
            S_VAR_DIV_GO:   cmd.var_div_start = 1'b1;
            S_VAR_DIV_WAIT:
            begin
                cmd.var_store = stat.div_done;
                cmd.clr       = stat.div_done;
            end
            S_ROT_MUL:      cmd.rot_mul   = 1'b1;
            S_ROT_UPD:      cmd.angle_upd = 1'b1;
            S_VEL_MUL:      cmd.vel_mul   = 1'b1;
            S_VEL_UPD:      cmd.vel_upd   = 1'b1;
            S_DISP_MUL:     cmd.disp_mul  = 1'b1;
            S_DISP_UPD:     cmd.disp_upd  = 1'b1;
            S_OUT:          cmd.load_out  = out_free;
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new load wins over the departure of the previous word
            if (load_now)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        ch_reg    <= 1'b0;
                        state_reg <= S_AVG_SUM;
                    end
                S_AVG_SUM:
                    if (stat.avg_last)
                        state_reg <= S_AVG_DIV_GO;
                S_AVG_DIV_GO:
                    state_reg <= S_AVG_DIV_WAIT;
                S_AVG_DIV_WAIT:
                    if (stat.div_done)
                    begin
                        if (ch_reg)
                            state_reg <= S_PUSH_SM;
                        else
                        begin
                            ch_reg    <= 1'b1;
                            state_reg <= S_AVG_SUM;
                        end
                    end
                S_PUSH_SM:
                begin
                    ch_reg    <= 1'b0;
                    state_reg <= S_VAR_SUM;
                end
                S_VAR_SUM:
                    if (stat.var_last)
                        state_reg <= S_VAR_SQ;
                S_VAR_SQ:
                    state_reg <= S_VAR_DIV_GO;
                S_VAR_DIV_GO:
                    state_reg <= S_VAR_DIV_WAIT;
                S_VAR_DIV_WAIT:
                    if (stat.div_done)
                    begin
                        if (ch_reg)
                            state_reg <= S_ROT_MUL;
                        else
                        begin
                            ch_reg    <= 1'b1;
                            state_reg <= S_VAR_SUM;
                        end
                    end
                S_ROT_MUL:  state_reg <= S_ROT_UPD;
                S_ROT_UPD:  state_reg <= S_VEL_MUL;
                S_VEL_MUL:  state_reg <= S_VEL_UPD;
                S_VEL_UPD:  state_reg <= S_DISP_MUL;
                S_DISP_MUL: state_reg <= S_DISP_UPD;
                S_DISP_UPD: state_reg <= S_OUT;
                S_OUT:
                    if (out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/imu_gated_dead_reckoning.sv =====
// Top level of one axis of variance-gated IMU dead reckoning.
// Depends on igdr_pkg, igdr_if, igdr_ctrl, igdr_datapath and assert_macros.svh.
//
// Usage:
//   sensor : sink channel, one word = one accel sample and one gyro sample.
//   track  : source channel, one word per accepted sample word: smoothed
//            values, variances, gating flags, velocity, angle, displacement.
//   cfg_*  : register writes, taken on any edge with cfg_wr_en high. Write
//            only while no sample word is in flight.
// Flow: one word is worked on at a time; the next word is taken on the cycle
//   after the result is loaded. The time goes to walking the 16-entry windows
//   one tap a cycle, SL taps for an average and VL for a variance, SL and VL
//   being the clamped smoothing and variance lengths, and to four divisions
//   on one shared radix-4 divider.
// Reset: windows, sample count and integrators clear; registers take their
//   reset values; no result is pending.
// Stall: the result sits in an output register, so a stalled receiver does
//   not stop the next word from being worked on; only loading a new result
//   waits until the previous one has been taken.
`include "assert_macros.svh"

module imu_gated_dead_reckoning (
    input  logic                              clk,
    input  logic                              rst_n,
    igdr_in_if.sink                           sensor,
    igdr_out_if.source                        track,
    input  logic                              cfg_wr_en,
    input  logic [igdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [igdr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import igdr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer: one word at a time
    igdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sensor.valid),
        .in_ready  (sensor.ready),
        .out_valid (track.valid),
        .out_ready (track.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // windows, arithmetic, registers, result register
    igdr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (sensor.data),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_data  (track.data)
    );

    // a new word never lands while the divider is still working on the last one
    `ASSERT_IMPLIES(a_accept_idle_div, clk, rst_n, sensor.valid && sensor.ready, !dp_stat.div_busy)
    // the result register is only overwritten once its word has gone
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, dp_cmd.load_out, !track.valid || track.ready)
    // divider is never restarted mid-division
    `ASSERT_IMPLIES(a_div_start_idle, clk, rst_n, dp_cmd.avg_div_start || dp_cmd.var_div_start, !dp_stat.div_busy)
    // a started division is running on the next cycle
    `ASSERT_NEXT(a_div_runs, clk, rst_n, dp_cmd.avg_div_start || dp_cmd.var_div_start, dp_stat.div_busy)
endmodule
